// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the obb RTL files.
// No dependencies; define ASSERT_OFF to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check with active-low reset masking
`define OBB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check without reset masking
`define OBB_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OBB_ASSERT(lbl, clk, rst_n, prop, msg)
`define OBB_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/obb_pkg.sv =====
// Shared types, constants and tables for the obb wireframe edge block.
// No dependencies.
package obb_pkg;

    localparam int COORD_W    = 32;
    localparam int HALF_W     = 31;
    localparam int QUAT_W     = 16;
    localparam int COLOR_W    = 24;
    localparam int ENTRY_W    = 31;   // matrix entry, Q.28, limited to +-2^29
    localparam int RAW_W      = 35;   // unclamped matrix entry
    localparam int PROD_W     = ENTRY_W + HALF_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int EDGE_W     = 4;
    localparam int EDGE_COUNT = 12;
    localparam int FIFO_DEPTH = 2;

    localparam logic [EDGE_W-1:0] EDGE_LAST = EDGE_W'(EDGE_COUNT - 1);

    localparam logic signed [RAW_W-1:0] Q28_ONE   = RAW_W'(64'sd1 <<< 28);
    localparam logic signed [RAW_W-1:0] ENTRY_MAX = RAW_W'(64'sd1 <<< 29);
    localparam logic signed [RAW_W-1:0] ENTRY_MIN = -ENTRY_MAX;

    // box after matrix setup, row-major matrix
    typedef struct packed {
        logic [2:0][COORD_W-1:0] center;
        logic [2:0][HALF_W-1:0]  half;
        logic [8:0][ENTRY_W-1:0] mat;
        logic [COLOR_W-1:0]      color;
    } t_box;

    function automatic logic signed [ENTRY_W-1:0] sat_entry(logic signed [RAW_W-1:0] v);
        logic signed [RAW_W-1:0] r;
        r = v;
        if (v > ENTRY_MAX) r = ENTRY_MAX;
        if (v < ENTRY_MIN) r = ENTRY_MIN;
        return r[ENTRY_W-1:0];
    endfunction

    // bit j set: corner takes +half along axis j
    function automatic logic [2:0] corner_pos(logic [2:0] k);
        logic [2:0] s;
        unique case (k)
            3'd0: s = 3'b000;
            3'd1: s = 3'b001;
            3'd2: s = 3'b011;
            3'd3: s = 3'b010;
            3'd4: s = 3'b100;
            3'd5: s = 3'b101;
            3'd6: s = 3'b111;
            default: s = 3'b110;
        endcase
        return s;
    endfunction

    // corner pair of each edge: bottom ring, top ring, verticals
    function automatic logic [5:0] edge_ends(logic [EDGE_W-1:0] e);
        logic [5:0] r;
        unique case (e)
            4'd0:  r = {3'd0, 3'd1};
            4'd1:  r = {3'd1, 3'd2};
            4'd2:  r = {3'd2, 3'd3};
            4'd3:  r = {3'd3, 3'd0};
            4'd4:  r = {3'd4, 3'd5};
            4'd5:  r = {3'd5, 3'd6};
            4'd6:  r = {3'd6, 3'd7};
            4'd7:  r = {3'd7, 3'd4};
            4'd8:  r = {3'd0, 3'd4};
            4'd9:  r = {3'd1, 3'd5};
            4'd10: r = {3'd2, 3'd6};
            default: r = {3'd3, 3'd7};
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/obb_front.sv =====
// Front end: accepts boxes and builds the clamped rotation matrix, two stages.
// Depends on obb_pkg.
module obb_front import obb_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0][COORD_W-1:0]    i_center,
    input  logic [2:0][HALF_W-1:0]     i_half,
    input  logic signed [QUAT_W-1:0]   i_qw,
    input  logic signed [QUAT_W-1:0]   i_qx,
    input  logic signed [QUAT_W-1:0]   i_qy,
    input  logic signed [QUAT_W-1:0]   i_qz,
    input  logic [COLOR_W-1:0]         i_color,
    output logic                       o_push,
    output t_box                       o_box,
    input  logic                       i_full
);
    localparam int PW = 2 * QUAT_W;

    logic                    adv;
    logic                    r_f1_vld, r_f2_vld;
    logic signed [PW-1:0]    r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic [2:0][COORD_W-1:0] r_center;
    logic [2:0][HALF_W-1:0]  r_half;
    logic [COLOR_W-1:0]      r_color;
    t_box                    r_box, n_box;

    assign adv     = !r_f2_vld || !i_full;
    assign o_stall = !adv;
    assign o_push  = r_f2_vld && !i_full;
    assign o_box   = r_box;

    function automatic logic signed [RAW_W-1:0] dbl(logic signed [PW-1:0] a,
                                                    logic signed [PW-1:0] b, logic sub);
        logic signed [RAW_W-1:0] s;
        s = sub ? (RAW_W'(a) - RAW_W'(b)) : (RAW_W'(a) + RAW_W'(b));
        return s <<< 1;
    endfunction

    always_comb begin
        n_box.center = r_center;
        n_box.half   = r_half;
        n_box.color  = r_color;
        n_box.mat[0] = sat_entry(Q28_ONE - dbl(r_yy, r_zz, 1'b0));
        n_box.mat[1] = sat_entry(dbl(r_xy, r_wz, 1'b1));
        n_box.mat[2] = sat_entry(dbl(r_xz, r_wy, 1'b0));
        n_box.mat[3] = sat_entry(dbl(r_xy, r_wz, 1'b0));
        n_box.mat[4] = sat_entry(Q28_ONE - dbl(r_xx, r_zz, 1'b0));
        n_box.mat[5] = sat_entry(dbl(r_yz, r_wx, 1'b1));
        n_box.mat[6] = sat_entry(dbl(r_xz, r_wy, 1'b1));
        n_box.mat[7] = sat_entry(dbl(r_yz, r_wx, 1'b0));
        n_box.mat[8] = sat_entry(Q28_ONE - dbl(r_xx, r_yy, 1'b0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (adv) begin
            r_f1_vld <= i_valid;
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xx     <= i_qx * i_qx;
            r_yy     <= i_qy * i_qy;
            r_zz     <= i_qz * i_qz;
            r_xy     <= i_qx * i_qy;
            r_xz     <= i_qx * i_qz;
            r_yz     <= i_qy * i_qz;
            r_wx     <= i_qw * i_qx;
            r_wy     <= i_qw * i_qy;
            r_wz     <= i_qw * i_qz;
            r_center <= i_center;
            r_half   <= i_half;
            r_color  <= i_color;
            r_box    <= n_box;
        end
    end

endmodule

// ===== rtl/obb_fifo.sv =====
// Small queue of prepared boxes between front and back end.
// Depends on obb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module obb_fifo import obb_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_box i_box,
    input  logic i_pop,
    output t_box o_box,
    output logic o_full,
    output logic o_empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_box          mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_box   = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) mem[r_wr] <= i_box;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    `OBB_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `OBB_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty), "pop from empty queue")
    `OBB_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= CNT_FULL, "queue count out of range")

endmodule

// ===== rtl/obb_back.sv =====
// Back end: per-box products, then one edge per cycle, unless the output stalls, through sum and round stages.
// Depends on obb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module obb_back import obb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_box                      i_box,
    input  logic                      i_empty,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0][COORD_W-1:0]   o_start,
    output logic [2:0][COORD_W-1:0]   o_end,
    output logic [COLOR_W-1:0]        o_color,
    output logic [EDGE_W-1:0]         o_edge,
    output logic                      o_last
);
    localparam int RW = ACC_W - 28 + 1;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd1 <<< 27);
    localparam logic signed [RW-1:0] SAT_MAX = RW'(64'sd2147483647);
    localparam logic signed [RW-1:0] SAT_MIN = RW'(-64'sd2147483648);

    logic                     adv, issue, load;
    logic                     r_m_vld, r_s_vld;
    logic [EDGE_W-1:0]        r_edge;
    logic signed [PROD_W-1:0] r_p [3][3];
    logic signed [PROD_W-1:0] prod [3][3];
    logic [2:0][COORD_W-1:0]  r_m_center, r_s_center;
    logic [COLOR_W-1:0]       r_m_color, r_s_color;
    logic [EDGE_W-1:0]        r_s_edge;
    logic signed [ACC_W-1:0]  r_sa [3], r_sb [3], n_sa [3], n_sb [3];
    logic [2:0][COORD_W-1:0]  n_start, n_end;
    logic [5:0]               ends;

    assign adv   = !(o_valid && i_stall);
    assign issue = r_m_vld && adv;
    assign load  = !i_empty && (!r_m_vld || (issue && r_edge == EDGE_LAST));
    assign o_pop = load;
    assign ends  = edge_ends(r_edge);

    function automatic logic signed [ACC_W-1:0] corner_sum(
        logic signed [PROD_W-1:0] p0, logic signed [PROD_W-1:0] p1,
        logic signed [PROD_W-1:0] p2, logic [2:0] pos);
        logic signed [ACC_W-1:0] a0, a1, a2;
        a0 = pos[0] ? ACC_W'(p0) : -ACC_W'(p0);
        a1 = pos[1] ? ACC_W'(p1) : -ACC_W'(p1);
        a2 = pos[2] ? ACC_W'(p2) : -ACC_W'(p2);
        return a0 + a1 + a2;
    endfunction

    // round half up to Q16.16, add center, saturate
    function automatic logic [COORD_W-1:0] finish(logic signed [ACC_W-1:0] acc,
                                                  logic [COORD_W-1:0] c);
        logic signed [ACC_W-1:0] t;
        logic signed [RW-1:0]    r;
        t = (acc + HALF_LSB) >>> 28;
        r = RW'($signed(t[ACC_W-29:0])) + RW'($signed(c));
        if (r > SAT_MAX) r = SAT_MAX;
        if (r < SAT_MIN) r = SAT_MIN;
        return r[COORD_W-1:0];
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod[i][j] = $signed(i_box.mat[3*i+j]) * $signed({1'b0, i_box.half[j]});
            end
            n_sa[i] = corner_sum(r_p[i][0], r_p[i][1], r_p[i][2], corner_pos(ends[5:3]));
            n_sb[i] = corner_sum(r_p[i][0], r_p[i][1], r_p[i][2], corner_pos(ends[2:0]));
            n_start[i] = finish(r_sa[i], r_s_center[i]);
            n_end[i]   = finish(r_sb[i], r_s_center[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_s_vld <= 1'b0;
            o_valid <= 1'b0;
            r_edge  <= '0;
        end else begin
            if (load) r_m_vld <= 1'b1;
            else if (issue && r_edge == EDGE_LAST) r_m_vld <= 1'b0;
            if (issue) r_edge <= (r_edge == EDGE_LAST) ? '0 : r_edge + 1'b1;
            if (adv) begin
                r_s_vld <= issue;
                o_valid <= r_s_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_p        <= prod;
            r_m_center <= i_box.center;
            r_m_color  <= i_box.color;
        end
        if (adv) begin
            r_sa       <= n_sa;
            r_sb       <= n_sb;
            r_s_center <= r_m_center;
            r_s_color  <= r_m_color;
            r_s_edge   <= r_edge;
            o_start    <= n_start;
            o_end      <= n_end;
            o_color    <= r_s_color;
            o_edge     <= r_s_edge;
            o_last     <= (r_s_edge == EDGE_LAST);
        end
    end

    `OBB_ASSERT(a_edge_range, i_clk, i_rst_n, r_edge <= EDGE_LAST, "edge counter out of range")
    `OBB_ASSERT(a_last_mark, i_clk, i_rst_n, o_valid |-> (o_last == (o_edge == EDGE_LAST)), "last mark wrong")
    `OBB_ASSERT(a_load_idle, i_clk, i_rst_n, (load && r_m_vld) |-> (r_edge == EDGE_LAST), "box replaced mid sequence")
    `OBB_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_edge)), "stalled edge changed")

endmodule

// ===== rtl/obb_wireframe_edges.sv =====
// Top level of the oriented-box wireframe edge generator.
// Depends on obb_pkg, obb_front, obb_fifo, obb_back.
//
// Input channel: one box per item (center, half extents, Q1.14 quaternion,
// color), accepted when i_valid is high and o_stall is low.
// Output channel: twelve line items per box, edge_number 0..11 in order
// (bottom ring, top ring, verticals); o_last_edge marks the twelfth. An item
// is taken when o_valid is high and i_stall is low.
// Throughput: one edge per cycle while i_stall is low and boxes are queued; the
// edge sequencer in the back end, which walks the edges of the box held
// in its product registers, sets that rate.
// Path: a box passes two matrix stages, the queue, product load, the sum stage
// and the output register before its first edge appears.
// Front and back are joined by a queue of DEPTH boxes (FIFO_DEPTH by default), so new boxes are
// taken while edges are still being emitted.
// Reset (synchronous, active low) empties all stages and the queue.
// While o_valid and i_stall are high the output holds and the back end stops issuing edges;
// the front raises o_stall once the queue is full and its last stage holds a box.
module obb_wireframe_edges import obb_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic [HALF_W-1:0]         i_half_x,
    input  logic [HALF_W-1:0]         i_half_y,
    input  logic [HALF_W-1:0]         i_half_z,
    input  logic signed [QUAT_W-1:0]  i_quat_w,
    input  logic signed [QUAT_W-1:0]  i_quat_x,
    input  logic signed [QUAT_W-1:0]  i_quat_y,
    input  logic signed [QUAT_W-1:0]  i_quat_z,
    input  logic [COLOR_W-1:0]        i_color_rgb,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [COORD_W-1:0] o_start_x,
    output logic signed [COORD_W-1:0] o_start_y,
    output logic signed [COORD_W-1:0] o_start_z,
    output logic signed [COORD_W-1:0] o_end_x,
    output logic signed [COORD_W-1:0] o_end_y,
    output logic signed [COORD_W-1:0] o_end_z,
    output logic [COLOR_W-1:0]        o_line_color,
    output logic [EDGE_W-1:0]         o_edge_number,
    output logic                      o_last_edge
);
    t_box                    f_box, q_box;
    logic                    push, pop, full, empty;
    logic [2:0][COORD_W-1:0] start_v, end_v;

    obb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_center ({i_center_z, i_center_y, i_center_x}),
        .i_half   ({i_half_z, i_half_y, i_half_x}),
        .i_qw     (i_quat_w),
        .i_qx     (i_quat_x),
        .i_qy     (i_quat_y),
        .i_qz     (i_quat_z),
        .i_color  (i_color_rgb),
        .o_push   (push),
        .o_box    (f_box),
        .i_full   (full)
    );

    obb_fifo #(.DEPTH(DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_box   (f_box),
        .i_pop   (pop),
        .o_box   (q_box),
        .o_full  (full),
        .o_empty (empty)
    );

    obb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (q_box),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_start (start_v),
        .o_end   (end_v),
        .o_color (o_line_color),
        .o_edge  (o_edge_number),
        .o_last  (o_last_edge)
    );

    assign o_start_x = start_v[0];
    assign o_start_y = start_v[1];
    assign o_start_z = start_v[2];
    assign o_end_x   = end_v[0];
    assign o_end_y   = end_v[1];
    assign o_end_z   = end_v[2];

endmodule

// ===== bench/obb_wireframe_edges_test.sv =====
// Self-checking bench for obb_wireframe_edges: random and directed boxes,
// predicted edges compared field by field. Depends on obb_pkg and the RTL.
module obb_wireframe_edges_test;
    import obb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic [23:0] color;
        logic [3:0]  num;
        logic        last;
    } t_edge;

    class t_edge_board;
        t_edge pending[$];
        int    errors;
        int    boxes;
        int    edges_seen;

        function automatic longint floor28(longint v);
            return v >>> 28;
        endfunction

        function automatic longint clampv(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_box(logic signed [31:0] c[3], logic [30:0] h[3],
                               logic signed [15:0] qw, qx, qy, qz, logic [23:0] col);
            longint m[3][3];
            longint corner[8][3];
            longint w, x, y, z, acc, lim, hs;
            int a, b;
            logic [2:0] pos;
            t_edge e;
            w = qw; x = qx; y = qy; z = qz;
            lim = 64'sd1 <<< 29;
            m[0][0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
            m[0][1] = 2 * (x * y - w * z);
            m[0][2] = 2 * (x * z + w * y);
            m[1][0] = 2 * (x * y + w * z);
            m[1][1] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
            m[1][2] = 2 * (y * z - w * x);
            m[2][0] = 2 * (x * z - w * y);
            m[2][1] = 2 * (y * z + w * x);
            m[2][2] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m[i][j] = clampv(m[i][j], -lim, lim);
            for (int k = 0; k < 8; k++) begin
                // bottom ring walks -,-  +,-  +,+  -,+ ; top ring the same at +z
                pos[0] = (k % 4 == 1) || (k % 4 == 2);
                pos[1] = (k % 4 >= 2);
                pos[2] = (k >= 4);
                for (int i = 0; i < 3; i++) begin
                    acc = 0;
                    for (int j = 0; j < 3; j++) begin
                        hs = pos[j] ? longint'(h[j]) : -longint'(h[j]);
                        acc += m[i][j] * hs;
                    end
                    corner[k][i] = clampv(floor28(acc + (64'sd1 <<< 27)) + longint'(c[i]),
                                          -64'sd2147483648, 64'sd2147483647);
                end
            end
            for (int k = 0; k < 12; k++) begin
                if (k < 8) begin
                    a = (k / 4) * 4 + k % 4;
                    b = (k / 4) * 4 + (k + 1) % 4;
                end else begin
                    a = k - 8;
                    b = k - 4;
                end
                e.sx = 32'(corner[a][0]); e.sy = 32'(corner[a][1]); e.sz = 32'(corner[a][2]);
                e.ex = 32'(corner[b][0]); e.ey = 32'(corner[b][1]); e.ez = 32'(corner[b][2]);
                e.color = col;
                e.num = 4'(k);
                e.last = (k == 11);
                pending = {pending, e};
            end
            boxes++;
        endfunction

        function void cmp(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_edge(t_edge got);
            t_edge w;
            edges_seen++;
            if (pending.size() == 0) begin
                $error("edge %0d with nothing expected", got.num);
                errors++;
                return;
            end
            w = pending.pop_front();
            cmp("start_x", w.sx, got.sx);
            cmp("start_y", w.sy, got.sy);
            cmp("start_z", w.sz, got.sz);
            cmp("end_x", w.ex, got.ex);
            cmp("end_y", w.ey, got.ey);
            cmp("end_z", w.ez, got.ez);
            cmp("line_color", w.color, got.color);
            cmp("edge_number", w.num, got.num);
            cmp("last_edge", w.last, got.last);
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic o_stall, o_valid, o_last_edge;
    logic signed [31:0] i_center_x = 0, i_center_y = 0, i_center_z = 0;
    logic [30:0] i_half_x = 0, i_half_y = 0, i_half_z = 0;
    logic signed [15:0] i_quat_w = 0, i_quat_x = 0, i_quat_y = 0, i_quat_z = 0;
    logic [23:0] i_color_rgb = 0;
    logic signed [31:0] o_start_x, o_start_y, o_start_z, o_end_x, o_end_y, o_end_z;
    logic [23:0] o_line_color;
    logic [3:0]  o_edge_number;

    t_edge_board board = new();
    int stall_mode = 0;

    obb_wireframe_edges i_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("obb_wireframe_edges_test NOT OK");
        $finish;
    end

    // receiver: stall pattern changes mode now and then, some stretches never stall
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_edge g;
        if (i_rst_n && o_valid && !i_stall) begin
            g.sx = o_start_x; g.sy = o_start_y; g.sz = o_start_z;
            g.ex = o_end_x; g.ey = o_end_y; g.ez = o_end_z;
            g.color = o_line_color; g.num = o_edge_number; g.last = o_last_edge;
            board.check_edge(g);
        end
    end

    task automatic send_box(logic signed [31:0] cx, cy, cz, logic [30:0] hx, hy, hz,
                            logic signed [15:0] qw, qx, qy, qz, logic [23:0] col);
        logic signed [31:0] c[3];
        logic [30:0] h[3];
        i_center_x <= cx; i_center_y <= cy; i_center_z <= cz;
        i_half_x <= hx; i_half_y <= hy; i_half_z <= hz;
        i_quat_w <= qw; i_quat_x <= qx; i_quat_y <= qy; i_quat_z <= qz;
        i_color_rgb <= col;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        c = '{cx, cy, cz};
        h = '{hx, hy, hz};
        board.note_box(c, h, qw, qx, qy, qz, col);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rq();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom);       // may fall far out of range, entries then saturate
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [30:0] rh();
        case ($urandom_range(0, 4))
            0: return 31'h7fffffff;
            1: return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h00ff_ffff));
        endcase
    endfunction

    function automatic logic signed [31:0] rc();
        case ($urandom_range(0, 4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
        endcase
    endfunction

    initial begin
        int wait_cnt;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: identity, extremes, saturation, half turns, oversize quaternion
        send_box(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 24'h000000);
        send_box(65536, -65536, 0, 65536, 131072, 196608, 16384, 0, 0, 0, 24'hffffff);
        send_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff,
                 31'h7fffffff, 16384, 0, 0, 0, 24'hff0000);
        send_box(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff, 31'h7fffffff,
                 31'h7fffffff, -16384, 0, 0, 0, 24'h00ff00);
        send_box(0, 0, 0, 65536, 65536, 65536, 0, 16384, 0, 0, 24'h0000ff);
        send_box(0, 0, 0, 65536, 65536, 65536, 0, 0, 16384, 0, 24'h123456);
        send_box(0, 0, 0, 65536, 65536, 65536, 0, 0, 0, -16384, 24'habcdef);
        send_box(100, 200, 300, 65536, 32768, 1, 11585, 11585, 0, 0, 24'h555555);
        send_box(0, 0, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 24'haaaaaa);
        send_box(0, 0, 0, 31'h7fffffff, 1, 31'h7fffffff,
                 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 24'h0f0f0f);
        send_box(-1, 1, -1, 3, 5, 7, 0, 0, 0, 0, 24'hf0f0f0);
        send_box(0, 0, 0, 1, 1, 1, 8192, 8192, 8192, 8192, 24'h800001);

        // hold off until the pipeline drains
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);

        for (int n = 0; n < 180; n++) begin
            if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 30));
            send_box(rc(), rc(), rc(), rh(), rh(), rh(), rq(), rq(), rq(), rq(), $urandom);
        end
        i_valid <= 1'b0;

        wait_cnt = 0;
        while (board.pending.size() != 0 && wait_cnt < 100000) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (20) @(negedge i_clk);
        $display("ran %0d boxes, checked %0d edges, including saturating and oversize cases",
                 board.boxes, board.edges_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("obb_wireframe_edges_test OK");
        else
            $display("obb_wireframe_edges_test NOT OK");
        $finish;
    end
endmodule
